@@ sv/mpbm_pkg.sv @@
// Shared types and codes for the multi-pattern byte matcher.
package mpbm_pkg;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_LEN   = 2'd1;
    localparam logic [1:0] FUNC_DATA  = 2'd2;
    localparam logic [1:0] FUNC_START = 2'd3;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    typedef struct packed {
        logic       data_en;
        logic       clear;
        logic       load_en;
        logic [2:0] sel;
        logic [5:0] pos;
        logic [7:0] value;
    } t_cell_ctl;

endpackage

@@ sv/mpbm_cell.sv @@
// One window position: the stream byte held there, its valid bit and that byte of every pattern.
module mpbm_cell
    import mpbm_pkg::*;
#(
    parameter int NUM_PATTERNS = 8,
    parameter int IDX          = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cell_ctl                    i_ctl,
    input  logic [7:0]                   i_win,
    input  logic                         i_vld,
    input  logic [NUM_PATTERNS-1:0][7:0] i_cmp,
    output logic [7:0]                   o_win,
    output logic                         o_vld,
    output logic [NUM_PATTERNS-1:0]      o_eq
);

    logic [7:0] r_pat [NUM_PATTERNS];
    logic [7:0] r_win;
    logic       r_vld;
    logic       w_wr;

    assign w_wr = i_ctl.load_en && (int'(i_ctl.pos) == IDX);

    // i_cmp[k] is the window byte lined up with this position of pattern k
    always_comb begin
        for (int k = 0; k < NUM_PATTERNS; k++) begin
            o_eq[k] = (r_pat[k] == i_cmp[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_PATTERNS; k++) begin
            if (w_wr && (int'(i_ctl.sel) == k)) begin
                r_pat[k] <= i_ctl.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
            r_vld <= 1'b0;
        end else if (i_ctl.clear) begin
            r_win <= '0;
            r_vld <= 1'b0;
        end else if (i_ctl.data_en) begin
            r_win <= i_win;
            r_vld <= i_vld;
        end
    end

    assign o_win = r_win;
    assign o_vld = r_vld;

endmodule

@@ sv/multi_pattern_byte_matcher.sv @@
// Top level of the multi-pattern byte matcher: cell chain, lengths, offset and output stage.
// Takes one item per clock while results are taken. An output register and a skid register
// sit behind the matcher: a result held back parks the next data result in the skid register,
// and the input is then held off until the skid register drains. Each data byte's result
// is registered in the output register, or in the skid register while one is held back.
// The stream window runs through a row of MAX_LEN cells; each cell holds one window byte
// with its valid bit, hands it to the next cell on every data byte, and holds the byte of
// every pattern at its position. For each pattern the incoming window is lined up with the
// pattern's length by a shifter and compared in all cells in the same cycle, so loads and
// length changes count from the next byte on. Load, length and start items give no result.
// The offset of each byte counts from the last start item and sticks at all ones.
module multi_pattern_byte_matcher
    import mpbm_pkg::*;
#(
    parameter int NUM_PATTERNS = 8,
    parameter int MAX_LEN      = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // pattern_sel[2:0], byte_pos[8:3], byte_value[16:9], pattern_length[23:17]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // func[1:0]
    input  logic [1:0]            i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // match_mask[7:0], end_offset[39:8]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam int LW      = $clog2(MAX_LEN + 1);
    localparam int LCW     = (LW > 7) ? LW : 7;
    localparam int NUM_OUT = (NUM_PATTERNS < 8) ? NUM_PATTERNS : 8;

    logic       w_acc;
    logic [1:0] w_func;
    logic [2:0] w_sel;
    logic [5:0] w_pos;
    logic [7:0] w_val;
    logic [6:0] w_len;
    logic [LCW-1:0] w_len_ext;
    logic [LCW-1:0] w_len_sat;
    logic       w_push;
    logic       w_pop;
    t_cell_ctl  w_ctl;

    logic [7:0]              w_win  [MAX_LEN];
    logic                    w_vld  [MAX_LEN];
    logic [7:0]              w_nwin [MAX_LEN];
    logic                    w_nvld [MAX_LEN];
    logic [MAX_LEN*8-1:0]    w_rev_win;
    logic [MAX_LEN-1:0]      w_rev_vld;
    logic [MAX_LEN*8-1:0]    w_al_win [NUM_PATTERNS];
    logic [MAX_LEN-1:0]      w_al_vld [NUM_PATTERNS];
    logic [NUM_PATTERNS-1:0][7:0] w_cmp [MAX_LEN];
    logic [NUM_PATTERNS-1:0] w_eq  [MAX_LEN];

    logic [LW-1:0]   r_len [NUM_PATTERNS];
    logic [31:0]     r_offset;
    logic [7:0]      n_mask;
    logic [OUT_DATA_W-1:0] w_res;
    logic [OUT_DATA_W-1:0] r_out;
    logic [OUT_DATA_W-1:0] r_skid;
    logic            r_out_vld;
    logic            r_skid_vld;

    assign w_func = i_s_axis_tuser;
    assign w_sel  = i_s_axis_tdata[2:0];
    assign w_pos  = i_s_axis_tdata[8:3];
    assign w_val  = i_s_axis_tdata[16:9];
    assign w_len  = i_s_axis_tdata[23:17];

    assign o_s_axis_tready = !r_skid_vld;
    assign w_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_push = w_acc && (w_func == FUNC_DATA);
    assign w_pop  = r_out_vld && i_m_axis_tready;

    assign w_ctl.data_en = w_push;
    assign w_ctl.clear   = w_acc && (w_func == FUNC_START);
    assign w_ctl.load_en = w_acc && (w_func == FUNC_LOAD) && (int'(w_sel) < NUM_PATTERNS);
    assign w_ctl.sel     = w_sel;
    assign w_ctl.pos     = w_pos;
    assign w_ctl.value   = w_val;

    // window as it stands once the incoming byte is shifted in, newest at cell 0
    for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
        if (j == 0) begin : g_head
            assign w_nwin[j] = w_val;
            assign w_nvld[j] = 1'b1;
        end else begin : g_link
            assign w_nwin[j] = w_win[j-1];
            assign w_nvld[j] = w_vld[j-1];
        end
        mpbm_cell #(
            .NUM_PATTERNS(NUM_PATTERNS),
            .IDX         (j)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (w_ctl),
            .i_win  (w_nwin[j]),
            .i_vld  (w_nvld[j]),
            .i_cmp  (w_cmp[j]),
            .o_win  (w_win[j]),
            .o_vld  (w_vld[j]),
            .o_eq   (w_eq[j])
        );
    end

    always_comb begin
        for (int j = 0; j < MAX_LEN; j++) begin
            w_rev_win[8*(MAX_LEN-1-j) +: 8] = w_nwin[j];
            w_rev_vld[MAX_LEN-1-j]          = w_nvld[j];
        end
    end

    // byte j of pattern k lines up with the window byte len-1-j
    for (genvar k = 0; k < NUM_PATTERNS; k++) begin : g_align
        logic [LW-1:0] w_shift;
        assign w_shift     = LW'(MAX_LEN) - r_len[k];
        assign w_al_win[k] = w_rev_win >> {w_shift, 3'b000};
        assign w_al_vld[k] = w_rev_vld >> w_shift;
    end

    always_comb begin
        for (int j = 0; j < MAX_LEN; j++) begin
            for (int k = 0; k < NUM_PATTERNS; k++) begin
                w_cmp[j][k] = w_al_win[k][8*j +: 8];
            end
        end
    end

    assign w_len_ext = LCW'(w_len);
    assign w_len_sat = (w_len_ext > LCW'(MAX_LEN)) ? LCW'(MAX_LEN) : w_len_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_PATTERNS; k++) begin
                r_len[k] <= '0;
            end
        end else if (w_acc && (w_func == FUNC_LEN)) begin
            for (int k = 0; k < NUM_PATTERNS; k++) begin
                if (int'(w_sel) == k) begin
                    r_len[k] <= LW'(w_len_sat);
                end
            end
        end
    end

    // pattern k ends here when its length is nonzero and every position below it holds a stream byte that matches
    always_comb begin
        logic w_ok;
        n_mask = '0;
        for (int k = 0; k < NUM_OUT; k++) begin
            w_ok = (r_len[k] != '0);
            for (int j = 0; j < MAX_LEN; j++) begin
                if (LW'(j) < r_len[k]) begin
                    w_ok = w_ok && w_al_vld[k][j] && w_eq[j][k];
                end
            end
            n_mask[k] = w_ok;
        end
    end

    assign w_res = {r_offset, n_mask};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (w_ctl.clear) begin
            r_offset <= '0;
        end else if (w_push && (r_offset != '1)) begin
            r_offset <= r_offset + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || w_pop) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= w_push;
            end
        end else if (w_push) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || w_pop) begin
            r_out <= r_skid_vld ? r_skid : w_res;
        end else if (w_push) begin
            r_skid <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out;

endmodule

@@ sv/mpbm_checker.sv @@
// Port-level checks for the multi-pattern byte matcher, bound to the top level.
module mpbm_checker
    import mpbm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input logic [1:0]            i_s_axis_tuser,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic w_in_acc;

    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("stalled result item changed");

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input blocked with no result pending");

    a_data_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_s_axis_tuser == FUNC_DATA) && !o_m_axis_tvalid |=> o_m_axis_tvalid)
        else $error("data item gave no result");

    a_ctrl_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_s_axis_tuser != FUNC_DATA) && !o_m_axis_tvalid |=> !o_m_axis_tvalid)
        else $error("non-data item gave a result");

endmodule

bind multi_pattern_byte_matcher mpbm_checker u_mpbm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_s_axis_tvalid(i_s_axis_tvalid),
    .o_s_axis_tready(o_s_axis_tready),
    .i_s_axis_tdata (i_s_axis_tdata),
    .i_s_axis_tuser (i_s_axis_tuser),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata)
);
